/* hdl/motor_speed_pid_sequencer_macros.svh */
// Assertion macros for the checker file.
`ifndef MOTOR_SPEED_PID_SEQUENCER_MACROS_SVH
`define MOTOR_SPEED_PID_SEQUENCER_MACROS_SVH
// Implication that must hold at every rising edge outside reset.
`define MSPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define MSPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hdl/mspid_pkg.sv */
`default_nettype none
package mspid_pkg;
    localparam int DUTY_MAX_DEF       = 1000;
    localparam int PID_PERIOD_MS_DEF  = 10;
    localparam int RAMP_INC_DEF       = 5;
    localparam int RAMP_PERIOD_MS_DEF = 10;
    localparam int STOP_DEC_DEF       = 10;
    localparam int STOP_PERIOD_MS_DEF = 10;

    localparam logic [2:0] CFG_PROP  = 3'd0;
    localparam logic [2:0] CFG_INTEG = 3'd1;
    localparam logic [2:0] CFG_DERIV = 3'd2;
    localparam logic [2:0] CFG_ILIM  = 3'd3;
    localparam logic [2:0] CFG_FLOOR = 3'd4;
    localparam logic [2:0] CFG_STALL = 3'd5;
    localparam logic [2:0] CFG_FLOW  = 3'd6;
    localparam logic [2:0] CFG_FHIGH = 3'd7;

    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_UP    = 3'd1;
    localparam logic [2:0] MODE_RUN   = 3'd2;
    localparam logic [2:0] MODE_DOWN  = 3'd3;
    localparam logic [2:0] MODE_FAULT = 3'd4;

    localparam logic [31:0] SPEED_NUM = 32'd256000000;
    localparam int          LAMP_MS   = 250;

    typedef enum logic [3:0] {
        ST_IDLE, ST_TICK, ST_DIV, ST_MUL_P, ST_MUL_I, ST_MUL_D, ST_SUM, ST_OUT
    } t_state;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic tick;     // latch input, run tick logic
        logic div_go;   // start the speed divider
        logic mul_p;
        logic mul_i;
        logic mul_d;
        logic sum;
        logic finish;   // register result, raise output valid
    } t_cmd;

    typedef struct packed {
        logic need_pid; // this tick runs the PID update
        logic div_done;
    } t_stat;
endpackage
`default_nettype wire

/* hdl/mspid_ctrl.sv */
`default_nettype none
module mspid_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire                 i_out_free,
    input  mspid_pkg::t_stat    i_stat,
    output mspid_pkg::t_cmd     o_cmd,
    output logic                o_busy
);
    import mspid_pkg::*;
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_start) n_state = ST_TICK;
            ST_TICK:  n_state = i_stat.need_pid ? ST_DIV : ST_OUT;
            ST_DIV:   if (i_stat.div_done) n_state = ST_MUL_P;
            ST_MUL_P: n_state = ST_MUL_I;
            ST_MUL_I: n_state = ST_MUL_D;
            ST_MUL_D: n_state = ST_SUM;
            ST_SUM:   n_state = ST_OUT;
            ST_OUT:   if (i_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_busy = 1'b1;
        unique case (r_state)
            ST_IDLE:  o_busy = 1'b0;
            ST_TICK:  begin
                o_cmd.tick = 1'b1;
                o_cmd.div_go = i_stat.need_pid;
            end
            ST_MUL_P: o_cmd.mul_p = 1'b1;
            ST_MUL_I: o_cmd.mul_i = 1'b1;
            ST_MUL_D: o_cmd.mul_d = 1'b1;
            ST_SUM:   o_cmd.sum = 1'b1;
            ST_OUT:   o_cmd.finish = i_out_free;
            default:  ;
        endcase
    end
endmodule
`default_nettype wire

/* hdl/mspid_div.sv */
`default_nettype none
// Restoring divider of the speed constant by the pulse period, one bit a cycle.
module mspid_div (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_go,
    input  wire  [15:0]  i_den,
    output logic         o_done,
    output logic [15:0]  o_quot
);
    import mspid_pkg::*;
    logic [31:0] r_q;
    logic [16:0] r_rem;
    logic [15:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_run;
    logic [17:0] w_trial;
    logic [16:0] w_sh;

    assign w_sh    = {r_rem[15:0], r_q[31]};
    assign w_trial = {1'b0, w_sh} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_go) begin
            r_run <= 1'b1;
            r_cnt <= 6'd32;
        end else if (r_run) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) r_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_q   <= SPEED_NUM;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_run) begin
            if (!w_trial[17]) begin
                r_rem <= w_trial[16:0];
                r_q   <= {r_q[30:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[30:0], 1'b0};
            end
        end
    end

    assign o_done = !r_run && !i_go;
    always_comb begin
        if (r_den == 16'd0) o_quot = 16'd0;
        else if (r_q[31:16] != 16'd0) o_quot = 16'hFFFF;
        else o_quot = r_q[15:0];
    end
endmodule
`default_nettype wire

/* hdl/mspid_dp.sv */
`default_nettype none
module mspid_dp #(
    parameter int DUTY_MAX       = mspid_pkg::DUTY_MAX_DEF,
    parameter int PID_PERIOD_MS  = mspid_pkg::PID_PERIOD_MS_DEF,
    parameter int RAMP_INC       = mspid_pkg::RAMP_INC_DEF,
    parameter int RAMP_PERIOD_MS = mspid_pkg::RAMP_PERIOD_MS_DEF,
    parameter int STOP_DEC       = mspid_pkg::STOP_DEC_DEF,
    parameter int STOP_PERIOD_MS = mspid_pkg::STOP_PERIOD_MS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_accept,
    input  wire  [19:0]         i_item,
    input  wire                 i_cfg_we,
    input  wire  [2:0]          i_cfg_idx,
    input  wire  [17:0]         i_cfg_data,
    input  mspid_pkg::t_cmd     i_cmd,
    output mspid_pkg::t_stat    o_stat,
    output logic [30:0]         o_result
);
    import mspid_pkg::*;
    localparam int          DW   = $clog2(DUTY_MAX + 1);
    localparam logic [DW-1:0] DMAX = DW'(DUTY_MAX);
    localparam logic [DW-1:0] GOAL = DW'(DUTY_MAX * 2 / 5);
    localparam int          SW   = 36;  // signed Q.8 sum width

    logic [15:0] r_kp, r_ki, r_kd, r_stall;
    logic [17:0] r_ilim;
    logic [9:0]  r_floor;
    logic [5:0]  r_flow, r_fhigh;

    logic [19:0] r_item;
    logic [2:0]  r_mode;
    logic [DW-1:0] r_duty;
    logic [31:0] r_ms, r_pid_t, r_ramp_t, r_pulse_t;
    logic [15:0] r_prev, r_period, r_speed;
    logic        r_fresh, r_lamp;
    logic [7:0]  r_lmod;
    logic        r_lpar;
    logic signed [18:0] r_integ;
    logic signed [16:0] r_lerr, r_err;
    logic signed [SW-1:0] r_acc;
    logic signed [34:0] r_prod;
    logic [30:0] r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= '0; r_ki <= '0; r_kd <= '0;
            r_ilim <= 18'd25600; r_floor <= 10'd150; r_stall <= 16'd200;
            r_flow <= 6'd18; r_fhigh <= 6'd24;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PROP:  r_kp <= i_cfg_data[15:0];
                CFG_INTEG: r_ki <= i_cfg_data[15:0];
                CFG_DERIV: r_kd <= i_cfg_data[15:0];
                CFG_ILIM:  r_ilim <= i_cfg_data;
                CFG_FLOOR: r_floor <= i_cfg_data[9:0];
                CFG_STALL: r_stall <= i_cfg_data[15:0];
                CFG_FLOW:  r_flow <= i_cfg_data[5:0];
                CFG_FHIGH: r_fhigh <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) if (i_accept) r_item <= i_item;

    // Tick logic, applied at once in the tick cycle.
    logic [31:0] w_now, w_pulse, w_since;
    logic [15:0] w_period;
    logic        w_fresh, w_need;
    logic [2:0]  n_mode;
    logic [DW-1:0] n_duty, w_fl;
    logic [31:0] n_ramp, n_pid, n_pulse;
    logic        n_lamp, n_fresh, w_clr;
    logic [DW+8:0] w_up;
    logic [33:0] w_lim3;
    logic        w_trig, w_sel;
    logic [7:0]  n_lmod;
    logic        n_lpar;

    assign w_trig = r_item[0];
    assign w_sel  = r_item[1];
    assign w_now  = r_ms + 32'd1;
    assign w_period = r_item[2] ? r_item[19:4] - r_prev : r_period;
    assign w_fresh  = r_item[2] ? 1'b1 : r_fresh;
    assign w_pulse  = r_item[2] ? w_now : r_pulse_t;
    assign w_since  = w_now - w_pulse;
    assign w_fl     = (32'(r_floor) > 32'(DUTY_MAX)) ? DMAX : DW'(r_floor);
    assign w_up     = (DW+9)'(r_duty) + (DW+9)'(RAMP_INC);
    assign w_lim3   = {18'd0, r_stall} * 34'd3;

    // The millisecond count is tracked as a remainder and a quotient parity
    // over the blink half-period, so the lamp phase needs no divider.
    always_comb begin
        if (w_now == 32'd0) begin
            n_lmod = '0; n_lpar = 1'b0;
        end else if (r_lmod == 8'(LAMP_MS - 1)) begin
            n_lmod = '0; n_lpar = !r_lpar;
        end else begin
            n_lmod = r_lmod + 8'd1; n_lpar = r_lpar;
        end
    end

    always_comb begin
        n_mode = r_mode; n_duty = r_duty; n_ramp = r_ramp_t; n_pid = r_pid_t;
        n_pulse = w_pulse; n_lamp = r_lamp; n_fresh = w_fresh; w_clr = 1'b0;
        w_need = 1'b0;
        unique case (r_mode)
            MODE_IDLE: if (w_trig) begin
                w_clr = 1'b1; n_duty = w_fl; n_ramp = w_now + 32'(RAMP_PERIOD_MS);
                n_pulse = w_now; n_mode = MODE_UP;
            end
            MODE_UP: begin
                if (!w_trig) begin
                    n_mode = MODE_DOWN; n_ramp = w_now + 32'(STOP_PERIOD_MS);
                end else begin
                    if (w_now >= r_ramp_t) begin
                        n_ramp = w_now + 32'(RAMP_PERIOD_MS);
                        if (r_duty < GOAL)
                            n_duty = (w_up > (DW+9)'(GOAL)) ? GOAL : w_up[DW-1:0];
                        if (w_fresh) begin
                            n_fresh = 1'b0; n_pid = w_now + 32'(PID_PERIOD_MS);
                            n_mode = MODE_RUN;
                        end
                    end
                    if ({2'b00, w_since} > w_lim3) begin
                        n_duty = '0; n_lamp = 1'b1; n_mode = MODE_FAULT;
                    end
                end
            end
            MODE_RUN: begin
                if (!w_trig) begin
                    n_mode = MODE_DOWN; n_ramp = w_now + 32'(STOP_PERIOD_MS);
                end else if (w_since > {16'd0, r_stall}) begin
                    n_duty = '0; w_clr = 1'b1; n_lamp = 1'b1; n_mode = MODE_FAULT;
                end else if (w_now >= r_pid_t) begin
                    n_pid = w_now + 32'(PID_PERIOD_MS); w_need = 1'b1;
                end
            end
            MODE_DOWN: if (w_now >= r_ramp_t) begin
                n_ramp = w_now + 32'(STOP_PERIOD_MS);
                if (32'(r_duty) > 32'(STOP_DEC)) n_duty = r_duty - DW'(STOP_DEC);
                else begin
                    n_duty = '0; w_clr = 1'b1; n_mode = MODE_IDLE;
                end
            end
            MODE_FAULT: begin
                n_duty = '0;
                n_lamp = n_lpar;
                if (!w_trig) begin
                    w_clr = 1'b1; n_lamp = 1'b0; n_mode = MODE_IDLE;
                end
            end
            default: n_mode = MODE_IDLE;
        endcase
    end
    assign o_stat.need_pid = w_need;

    // Speed divider.
    logic w_ddone;
    logic [15:0] w_quot;
    mspid_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(i_cmd.div_go),
        .i_den(w_period), .o_done(w_ddone), .o_quot(w_quot)
    );
    assign o_stat.div_done = w_ddone;

    // Shared multiplier: one gain times one error per cycle.
    logic signed [15:0] w_ma;
    logic signed [17:0] w_mb;
    logic signed [16:0] w_err;
    logic signed [17:0] w_derr;
    logic signed [34:0] w_sh;
    logic signed [27:0] w_isum, w_iclamp;
    logic signed [19:0] w_ilim;

    assign w_err  = 17'($signed({5'd0, (w_sel ? r_fhigh : r_flow), 8'd0})
                  - $signed({1'b0, w_quot}));
    assign w_derr = 18'(r_err) - 18'(r_lerr);
    assign w_sh   = r_prod >>> 8;
    assign w_isum = 28'(r_integ) + 28'(w_sh);
    assign w_ilim = $signed({2'b00, r_ilim});

    always_comb begin
        if (w_isum > 28'(w_ilim)) w_iclamp = 28'(w_ilim);
        else if (w_isum < -28'(w_ilim)) w_iclamp = -28'(w_ilim);
        else w_iclamp = w_isum;
    end

    always_comb begin
        w_ma = $signed(r_kp); w_mb = 18'(w_err);
        if (i_cmd.mul_i) begin w_ma = $signed(r_ki); w_mb = 18'(r_err); end
        if (i_cmd.mul_d) begin w_ma = $signed(r_kd); w_mb = w_derr; end
    end

    logic signed [SW+1:0] w_tot;
    logic signed [SW+1:0] w_flq, w_maxq;
    assign w_tot  = (SW+2)'(r_acc) + (SW+2)'(w_sh);
    assign w_flq  = $signed({{(SW-16){1'b0}}, r_floor, 8'd0});
    assign w_maxq = $signed({{(SW-DW-6){1'b0}}, DMAX, 8'd0});
    logic [DW-1:0] w_pidd;
    always_comb begin
        if (w_tot < w_flq) w_pidd = w_fl;
        else if (w_tot > w_maxq) w_pidd = DMAX;
        else w_pidd = w_tot[DW+7:8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE; r_duty <= '0; r_ms <= '0; r_pid_t <= '0;
            r_ramp_t <= '0; r_pulse_t <= '0; r_prev <= '0; r_period <= '0;
            r_fresh <= 1'b0; r_integ <= '0; r_lerr <= '0; r_speed <= '0; r_lamp <= 1'b0;
            r_lmod <= '0; r_lpar <= 1'b0;
        end else begin
            if (i_cmd.tick) begin
                r_ms <= w_now; r_period <= w_period; r_pulse_t <= n_pulse;
                if (r_item[2]) r_prev <= r_item[19:4];
                r_fresh <= n_fresh; r_mode <= n_mode; r_duty <= n_duty;
                r_ramp_t <= n_ramp; r_pid_t <= n_pid; r_lamp <= n_lamp;
                r_lmod <= n_lmod; r_lpar <= n_lpar;
                if (w_clr) begin r_integ <= '0; r_lerr <= '0; end
            end
            if (i_cmd.mul_p) begin
                r_speed <= w_quot; r_err <= w_err;
            end
            if (i_cmd.mul_d) begin
                r_integ <= 19'(w_iclamp);
                r_lerr <= r_err;
            end
            if (i_cmd.sum) r_duty <= w_pidd;
        end
    end

    // The clamped integral joins the sum in the cycle where it is stored.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_p || i_cmd.mul_i || i_cmd.mul_d) r_prod <= 35'(w_ma * w_mb);
        else if (i_cmd.sum) r_prod <= '0;
        if (i_cmd.mul_i) r_acc <= SW'($signed({2'b00, r_duty, 8'd0})) + SW'(w_sh);
        else if (i_cmd.mul_d) r_acc <= r_acc + SW'(w_iclamp);
    end

    always_ff @(posedge i_clk) if (i_cmd.finish) r_res <= {r_speed, r_mode,
        (r_mode == MODE_FAULT), r_lamp, 10'(r_duty)};
    assign o_result = r_res;
endmodule
`default_nettype wire

/* hdl/motor_speed_pid_sequencer.sv */
`default_nettype none
// Channel   Dir  tdata fields (low bit up)                       tuser
// s_axis    in   capture_stamp[15:0]                              trigger_held, speed_select,
//                                                                 capture_seen
// m_axis    out  pwm_duty[9:0], fault_lamp, stalled, mode[2:0],   none
//                speed_fps_q8[15:0], zero fill to 32 bits
// config    in   write enable, index[2:0], data[17:0]             none
//
// A tick without a PID update passes from its transfer through the tick and
// output states until the input is ready again; a PID tick also waits on the
// 32-step speed divider and then runs the shared gain multiplier and the sum.
// Reset is synchronous and active low; it restores the register defaults.
// One tick is in work at a time; while a result is held by a stalled consumer,
// the next tick is still taken and computed but waits for the output, and the
// input stays blocked until the held result is taken.
module motor_speed_pid_sequencer #(
    parameter int DUTY_MAX       = mspid_pkg::DUTY_MAX_DEF,
    parameter int PID_PERIOD_MS  = mspid_pkg::PID_PERIOD_MS_DEF,
    parameter int RAMP_INC       = mspid_pkg::RAMP_INC_DEF,
    parameter int RAMP_PERIOD_MS = mspid_pkg::RAMP_PERIOD_MS_DEF,
    parameter int STOP_DEC       = mspid_pkg::STOP_DEC_DEF,
    parameter int STOP_PERIOD_MS = mspid_pkg::STOP_PERIOD_MS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [15:0]  s_axis_tdata,  // capture_stamp
    input  wire  [2:0]   s_axis_tuser,  // trigger_held, speed_select, capture_seen
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [31:0]  m_axis_tdata,  // pwm_duty, fault_lamp, stalled, mode, speed_fps_q8
    input  wire          i_cfg_we,
    input  wire  [2:0]   i_cfg_idx,
    input  wire  [17:0]  i_cfg_data
);
    import mspid_pkg::*;
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_busy, w_acc, r_ovalid;
    logic [30:0] w_res;

    // The sequencer idles until a tick arrives; the output register frees at a take.
    assign s_axis_tready = !w_busy;
    assign w_acc = s_axis_tvalid && s_axis_tready;

    mspid_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_acc),
        .i_out_free(!r_ovalid || m_axis_tready), .i_stat(w_stat),
        .o_cmd(w_cmd), .o_busy(w_busy)
    );

    mspid_dp #(
        .DUTY_MAX(DUTY_MAX), .PID_PERIOD_MS(PID_PERIOD_MS), .RAMP_INC(RAMP_INC),
        .RAMP_PERIOD_MS(RAMP_PERIOD_MS), .STOP_DEC(STOP_DEC),
        .STOP_PERIOD_MS(STOP_PERIOD_MS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(w_acc),
        .i_item({s_axis_tdata, 1'b0, s_axis_tuser[2], s_axis_tuser[1], s_axis_tuser[0]}),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_cmd(w_cmd), .o_stat(w_stat), .o_result(w_res)
    );

    // Result valid rises when the sequencer posts a result and falls on the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (w_cmd.finish) r_ovalid <= 1'b1;
        else if (m_axis_tready) r_ovalid <= 1'b0;
    end
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, w_res};
endmodule
`default_nettype wire

/* hdl/mspid_checker.sv */
`default_nettype none
`include "motor_speed_pid_sequencer_macros.svh"
module mspid_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         s_axis_tvalid,
    input wire         s_axis_tready,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [31:0]  m_axis_tdata
);
    import mspid_pkg::*;
    logic       w_lamp, w_stalled, w_is_fault, w_is_idle, w_wait;
    logic [9:0] w_duty;
    logic [2:0] w_mode;

    assign w_duty     = m_axis_tdata[9:0];
    assign w_lamp     = m_axis_tdata[10];
    assign w_stalled  = m_axis_tdata[11];
    assign w_mode     = m_axis_tdata[14:12];
    assign w_is_fault = (w_mode == MODE_FAULT);
    assign w_is_idle  = (w_mode == MODE_IDLE);
    assign w_wait     = m_axis_tvalid && !m_axis_tready;

    `MSPS_ASSERT_IMP(a_stall_flag, i_clk, i_rst_n, m_axis_tvalid, w_stalled == w_is_fault)
    `MSPS_ASSERT_IMP(a_fault_duty, i_clk, i_rst_n, m_axis_tvalid && w_stalled, w_duty == 10'd0)
    `MSPS_ASSERT_NEXT(a_no_take, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `MSPS_ASSERT_IMP(a_idle_lamp, i_clk, i_rst_n, m_axis_tvalid && w_is_idle, w_lamp == 1'b0)
    `MSPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_wait, m_axis_tvalid && $stable(m_axis_tdata))
endmodule
bind motor_speed_pid_sequencer mspid_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
